// ===== hdl/assert_macros.svh =====
// assertion helpers shared by the rtl modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on every rising clock edge out of reset
`define ASSERT_IMP(lbl, ck, rn, a, c) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (a) |-> (c)) \
		else $error("assertion failed: same-cycle implication");

// next-cycle implication, checked on every rising clock edge out of reset
`define ASSERT_NXT(lbl, ck, rn, a, c) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (a) |=> (c)) \
		else $error("assertion failed: next-cycle implication");

`endif

// ===== hdl/abo_pkg.sv =====
package abo_pkg;

	// signed coordinate width, covers frame positions and scan offsets
	localparam int CW = 9;

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 7;

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BORDER_THICKNESS = 2'd2;

	localparam logic [6:0] WIDTH_RESET     = 7'd64;
	localparam logic [6:0] HEIGHT_RESET    = 7'd64;
	localparam logic [2:0] THICKNESS_RESET = 3'd1;

	// item commands
	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_READ  = 1'b1;

	// packed pixel: alpha, blue, green, red from msb down
	localparam logic [31:0] PIX_WHITE = 32'hFFFF_FFFF;
	localparam logic [31:0] PIX_CLEAR = 32'h0000_0000;

	typedef logic signed [CW-1:0] crd_t;

	typedef struct packed {
		logic       cmd;
		logic [6:0] pos_x;
		logic [6:0] pos_y;
		logic [7:0] in_red;
		logic [7:0] in_green;
		logic [7:0] in_blue;
		logic [7:0] in_alpha;
	} abo_in_t;

	typedef struct packed {
		logic [7:0] out_red;
		logic [7:0] out_green;
		logic [7:0] out_blue;
		logic [7:0] out_alpha;
		logic       outside_frame;
	} abo_out_t;

	// controller to datapath
	typedef struct packed {
		logic wr_px;
		logic load_req;
		logic issue_center;
		logic load_center;
		logic scan_step;
		logic load_white;
		logic load_out;
	} abo_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic outside;
		logic center_opaque;
		logic zero_thick;
		logic hit;
		logic scan_last;
		logic out_free;
	} abo_sts_t;

endpackage

// ===== hdl/abo_if.sv =====
// input item channel
interface abo_in_if;
	import abo_pkg::*;

	logic    valid;
	logic    ready;
	abo_in_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// result item channel
interface abo_out_if;
	import abo_pkg::*;

	logic     valid;
	logic     ready;
	abo_out_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/abo_datapath.sv =====
`include "assert_macros.svh"

module abo_datapath import abo_pkg::*; #(
	parameter int MAX_SIDE      = 64,
	parameter int MAX_THICKNESS = 7
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  abo_in_t               in_data,
	input  abo_cmd_t              cmd,
	output abo_sts_t              sts,
	output logic                  out_valid,
	input  logic                  out_ready,
	output abo_out_t              out_data
);

	localparam int DEPTH = MAX_SIDE * MAX_SIDE;
	localparam int AW    = $clog2(DEPTH);

	logic [6:0]    width_q;
	logic [6:0]    height_q;
	logic [2:0]    thick_q;
	logic [6:0]    w_c;
	logic [6:0]    h_c;
	logic [2:0]    t_c;
	crd_t          w_s;
	crd_t          h_s;
	crd_t          t_s;
	logic          outside_d;
	logic          outside_q;
	crd_t          cx_q;
	crd_t          cy_q;
	crd_t          nx_q;
	crd_t          ny_q;
	crd_t          xlo_q;
	crd_t          xhi_q;
	crd_t          yhi_q;
	logic          center_in_q;
	logic          pend_q;
	logic [31:0]   mem [DEPTH];
	logic [31:0]   rdata_q;
	logic [31:0]   res_q;
	logic          wr_en;
	logic          rd_en;
	logic [AW-1:0] waddr;
	logic [AW-1:0] raddr;
	abo_out_t      out_q;
	logic          out_valid_q;

	function automatic logic in_image(crd_t x, crd_t y, crd_t wi, crd_t hi);
		return (x >= 0) && (y >= 0) && (x < wi) && (y < hi);
	endfunction

	function automatic logic [AW-1:0] addr_of(crd_t x, crd_t y);
		logic [AW-1:0] ux;
		logic [AW-1:0] uy;
		ux = AW'($unsigned(x));
		uy = AW'($unsigned(y));
		return AW'(uy * AW'(MAX_SIDE) + ux);
	endfunction

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
			thick_q  <= THICKNESS_RESET;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_IMAGE_WIDTH:      width_q  <= cfg_wdata;
				REG_IMAGE_HEIGHT:     height_q <= cfg_wdata;
				REG_BORDER_THICKNESS: thick_q  <= cfg_wdata[2:0];
				default: ;
			endcase
		end
	end

	// clamp configuration to the supported ranges
	always_comb begin
		if (width_q == 7'd0)
			w_c = 7'd1;
		else if (int'(width_q) > MAX_SIDE)
			w_c = 7'(MAX_SIDE);
		else
			w_c = width_q;
		if (height_q == 7'd0)
			h_c = 7'd1;
		else if (int'(height_q) > MAX_SIDE)
			h_c = 7'(MAX_SIDE);
		else
			h_c = height_q;
		if (int'(thick_q) > MAX_THICKNESS)
			t_c = 3'(MAX_THICKNESS);
		else
			t_c = thick_q;
	end

	assign w_s = $signed({{(CW-7){1'b0}}, w_c});
	assign h_s = $signed({{(CW-7){1'b0}}, h_c});
	assign t_s = $signed({{(CW-3){1'b0}}, t_c});

	// read position beyond the enlarged frame
	assign outside_d = ({1'b0, in_data.pos_x} >= ({1'b0, w_c} + {4'b0, t_c, 1'b0}))
		|| ({1'b0, in_data.pos_y} >= ({1'b0, h_c} + {4'b0, t_c, 1'b0}));

	// request and scan window registers
	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			outside_q <= outside_d;
			cx_q      <= $signed({{(CW-7){1'b0}}, in_data.pos_x}) - t_s;
			cy_q      <= $signed({{(CW-7){1'b0}}, in_data.pos_y}) - t_s;
		end
		if (cmd.issue_center) begin
			center_in_q <= in_image(cx_q, cy_q, w_s, h_s);
			xlo_q       <= cx_q - t_s;
			xhi_q       <= cx_q + t_s;
			yhi_q       <= cy_q + t_s;
			nx_q        <= cx_q - t_s;
			ny_q        <= cy_q - t_s;
		end else if (cmd.scan_step) begin
			if (nx_q == xhi_q) begin
				nx_q <= xlo_q;
				ny_q <= ny_q + crd_t'(1);
			end else begin
				nx_q <= nx_q + crd_t'(1);
			end
		end
	end

	// pending scan read that lies inside the image
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pend_q <= 1'b0;
		else if (cmd.issue_center)
			pend_q <= 1'b0;
		else if (cmd.scan_step)
			pend_q <= in_image(nx_q, ny_q, w_s, h_s);
	end

	// pixel store, one write or one read per cycle
	assign wr_en = cmd.wr_px && (int'(in_data.pos_x) < MAX_SIDE)
		&& (int'(in_data.pos_y) < MAX_SIDE);
	assign waddr = AW'(AW'(in_data.pos_y) * AW'(MAX_SIDE) + AW'(in_data.pos_x));
	assign rd_en = cmd.issue_center || cmd.scan_step;
	assign raddr = cmd.issue_center ? addr_of(cx_q, cy_q) : addr_of(nx_q, ny_q);

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[waddr] <= {in_data.in_alpha, in_data.in_blue, in_data.in_green,
				in_data.in_red};
		if (rd_en)
			rdata_q <= mem[raddr];
	end

	// result pixel
	always_ff @(posedge clk) begin
		if (cmd.load_center)
			res_q <= center_in_q ? rdata_q : PIX_CLEAR;
		else if (cmd.load_white)
			res_q <= PIX_WHITE;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.load_out)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_q.out_red       <= outside_q ? 8'd0 : res_q[7:0];
			out_q.out_green     <= outside_q ? 8'd0 : res_q[15:8];
			out_q.out_blue      <= outside_q ? 8'd0 : res_q[23:16];
			out_q.out_alpha     <= outside_q ? 8'd0 : res_q[31:24];
			out_q.outside_frame <= outside_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// status to the controller
	assign sts.outside       = outside_q;
	assign sts.center_opaque = center_in_q && (rdata_q[31:24] != 8'd0);
	assign sts.zero_thick    = (t_c == 3'd0);
	assign sts.hit           = pend_q && (rdata_q[31:24] != 8'd0);
	assign sts.scan_last     = (nx_q == xhi_q) && (ny_q == yhi_q);
	assign sts.out_free      = !out_valid_q || out_ready;

	`ASSERT_IMP(a_no_rw_clash, clk, arst_n, wr_en, !rd_en)
	`ASSERT_NXT(a_out_loaded, clk, arst_n, cmd.load_out, out_valid_q)

endmodule

// ===== hdl/abo_ctrl.sv =====
`include "assert_macros.svh"

module abo_ctrl import abo_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  logic     in_cmd,
	output logic     in_ready,
	input  abo_sts_t sts,
	output abo_cmd_t cmd
);

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_CENTER = 6'b000010,
		S_LOOK   = 6'b000100,
		S_SCAN   = 6'b001000,
		S_TAIL   = 6'b010000,
		S_FINISH = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   in_xfer;

	assign in_ready = (state_q == S_IDLE);
	assign in_xfer  = in_valid && in_ready;

	// next state and datapath commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_xfer && (in_cmd == CMD_READ)) begin
					cmd.load_req = 1'b1;
					state_d      = S_CENTER;
				end else if (in_xfer) begin
					cmd.wr_px = 1'b1;
				end
			end
			S_CENTER: begin
				if (sts.outside) begin
					state_d = S_FINISH;
				end else begin
					cmd.issue_center = 1'b1;
					state_d          = S_LOOK;
				end
			end
			S_LOOK: begin
				cmd.load_center = 1'b1;
				if (sts.center_opaque || sts.zero_thick)
					state_d = S_FINISH;
				else
					state_d = S_SCAN;
			end
			S_SCAN: begin
				if (sts.hit) begin
					cmd.load_white = 1'b1;
					state_d        = S_FINISH;
				end else begin
					cmd.scan_step = 1'b1;
					if (sts.scan_last)
						state_d = S_TAIL;
				end
			end
			S_TAIL: begin
				cmd.load_white = sts.hit;
				state_d        = S_FINISH;
			end
			S_FINISH: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	`ASSERT_NXT(a_read_starts, clk, arst_n, in_xfer && (in_cmd == CMD_READ), state_q == S_CENTER)
	`ASSERT_NXT(a_hit_ends_scan, clk, arst_n, (state_q == S_SCAN) && sts.hit, state_q == S_FINISH)

endmodule

// ===== hdl/alpha_outline_border.sv =====
// RGBA pixel store with an outline-and-margin read port. A write transfer stores one
// pixel and leaves the block ready, so another transfer is accepted in the next cycle. A
// read transfer names a position of the frame enlarged by border_thickness t on every
// side: a position beyond the frame skips the store reads, an opaque centre pixel or
// t = 0 ends after the centre read, and otherwise the (2t+1) x (2t+1) window is
// scanned at one store read per cycle, stopping at the first opaque pixel.
// The pixel store has a single read port. The whole image must be written before it
// is read; the store has no reset. A finished result waits in an output register
// while the next transfer is accepted.
module alpha_outline_border import abo_pkg::*; #(
	parameter int MAX_SIDE      = 64,
	parameter int MAX_THICKNESS = 7
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	abo_in_if.sink                in_ch,
	abo_out_if.source             out_ch
);

	abo_cmd_t cmd;
	abo_sts_t sts;

	// sequencing of each transfer
	abo_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_cmd   (in_ch.data.cmd),
		.in_ready (in_ch.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// pixel store, scan window and result registers
	abo_datapath #(
		.MAX_SIDE      (MAX_SIDE),
		.MAX_THICKNESS (MAX_THICKNESS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.in_data   (in_ch.data),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.out_data  (out_ch.data)
	);

endmodule
